// ----- design/nsc_pkg.sv -----
// Shared types and character codes for the NMEA sentence checksum framer.
`timescale 1ns / 1ps
`default_nettype none
package nsc_pkg;

  // Largest supported sentence store: 256 bytes.
  localparam int MaxAddrW = 8;
  localparam int MaxLenW  = 9;

  localparam logic [7:0] ChDollar = 8'h24;
  localparam logic [7:0] ChComma  = 8'h2C;
  localparam logic [7:0] ChStar   = 8'h2A;

  // Byte write into the sentence store.
  typedef struct packed {
    logic                en;
    logic [MaxAddrW-1:0] addr;
    logic [7:0]          data;
  } wr_req_t;

  // Request to read out a validated sentence of len bytes from address 0.
  typedef struct packed {
    logic               start;
    logic [MaxLenW-1:0] len;
  } emit_req_t;

endpackage
`default_nettype wire

// ----- design/nsc_parser.sv -----
// Sentence parser: phase tracking, checksum accumulation and store writes.
`timescale 1ns / 1ps
`default_nettype none
module nsc_parser
  import nsc_pkg::*;
#(
  parameter int MAX_LEN = 64
) (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      accept,
  input  wire logic [7:0] rx_char,
  output wr_req_t        wr_req,
  output emit_req_t      emit_req
);

  localparam int AddrW = $clog2(MAX_LEN);
  localparam int LenW  = $clog2(MAX_LEN + 1);

  typedef enum logic [3:0] {
    PH_IDLE   = 4'b0001,
    PH_HEADER = 4'b0010,
    PH_DATA   = 4'b0100,
    PH_DIGITS = 4'b1000
  } phase_t;

  function automatic logic [3:0] hex_value(input logic [7:0] ch);
    logic [3:0] v;
    v = 4'd0;
    if (ch >= 8'h30 && ch <= 8'h39) v = ch[3:0];
    else if ((ch >= 8'h61 && ch <= 8'h66) || (ch >= 8'h41 && ch <= 8'h46))
      v = ch[3:0] + 4'd9;
    return v;
  endfunction

  phase_t          phase, phase_next;
  logic [7:0]      running_xor, running_xor_next;
  logic [LenW-1:0] fill_count, fill_count_next;
  logic            hi_seen, hi_seen_next;
  logic [3:0]      hi_nib, hi_nib_next;
  logic            store_ok;

  assign store_ok = fill_count < LenW'(MAX_LEN);

  always_comb begin
    phase_next       = phase;
    running_xor_next = running_xor;
    fill_count_next  = fill_count;
    hi_seen_next     = hi_seen;
    hi_nib_next      = hi_nib;
    wr_req.en        = 1'b0;
    wr_req.addr      = MaxAddrW'(fill_count[AddrW-1:0]);
    wr_req.data      = rx_char;
    emit_req.start   = 1'b0;
    emit_req.len     = MaxLenW'(fill_count + LenW'(1));
    if (accept) begin
      if (phase == PH_IDLE) begin
        if (rx_char == ChDollar) begin
          wr_req.en        = 1'b1;
          wr_req.addr      = '0;
          fill_count_next  = LenW'(1);
          running_xor_next = 8'd0;
          phase_next       = PH_HEADER;
        end
      end else if (!store_ok) begin
        // overlong: drop the sentence silently
        phase_next       = PH_IDLE;
        fill_count_next  = '0;
        running_xor_next = 8'd0;
      end else begin
        wr_req.en       = 1'b1;
        fill_count_next = fill_count + LenW'(1);
        unique case (phase)
          PH_HEADER: begin
            running_xor_next = running_xor ^ rx_char;
            if (rx_char == ChComma) phase_next = PH_DATA;
          end
          PH_DATA: begin
            if (rx_char == ChStar) begin
              phase_next   = PH_DIGITS;
              hi_seen_next = 1'b0;
            end else begin
              running_xor_next = running_xor ^ rx_char;
            end
          end
          PH_DIGITS: begin
            if (!hi_seen) begin
              hi_seen_next = 1'b1;
              hi_nib_next  = hex_value(rx_char);
            end else begin
              emit_req.start   = ({hi_nib, hex_value(rx_char)} == running_xor);
              phase_next       = PH_IDLE;
              fill_count_next  = '0;
              running_xor_next = 8'd0;
              hi_seen_next     = 1'b0;
            end
          end
          default: phase_next = PH_IDLE;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_IDLE;
      running_xor <= 8'd0;
      fill_count  <= '0;
      hi_seen     <= 1'b0;
    end else begin
      phase       <= phase_next;
      running_xor <= running_xor_next;
      fill_count  <= fill_count_next;
      hi_seen     <= hi_seen_next;
    end
  end

  always_ff @(posedge clk) begin
    hi_nib <= hi_nib_next;
  end

endmodule
`default_nettype wire

// ----- design/nsc_store.sv -----
// Sentence store memory with read-out sequencer and output register.
`timescale 1ns / 1ps
`default_nettype none
module nsc_store
  import nsc_pkg::*;
#(
  parameter int MAX_LEN = 64
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire wr_req_t    wr_req,
  input  wire emit_req_t  emit_req,
  output logic            busy,
  output logic            m_tvalid,
  input  wire logic       m_tready,
  output logic [7:0]      m_tdata,
  output logic            m_tlast
);

  localparam int AddrW = $clog2(MAX_LEN);
  localparam int LenW  = $clog2(MAX_LEN + 1);

  logic [7:0]       mem [MAX_LEN];
  logic [7:0]       mem_q;
  logic             rd_active;
  logic [AddrW-1:0] rd_addr;
  logic [LenW-1:0]  rd_len;
  logic             rd_pending;
  logic             pend_last;
  logic             issue;
  logic             issue_last;

  assign busy       = rd_active;
  assign issue      = rd_active && !rd_pending && (!m_tvalid || m_tready);
  assign issue_last = (LenW'(rd_addr) + LenW'(1)) == rd_len;

  always_ff @(posedge clk) begin
    if (wr_req.en) mem[wr_req.addr[AddrW-1:0]] <= wr_req.data;
    mem_q <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_active  <= 1'b0;
      rd_pending <= 1'b0;
      m_tvalid   <= 1'b0;
      rd_addr    <= '0;
    end else begin
      if (emit_req.start) begin
        rd_active <= 1'b1;
        rd_addr   <= '0;
      end else if (issue) begin
        rd_addr <= rd_addr + AddrW'(1);
        if (issue_last) rd_active <= 1'b0;
      end
      rd_pending <= issue;
      if (rd_pending) m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_req.start) rd_len <= emit_req.len[LenW-1:0];
    if (issue) pend_last <= issue_last;
    if (rd_pending) begin
      m_tdata <= mem_q;
      m_tlast <= pend_last;
    end
  end

endmodule
`default_nettype wire

// ----- design/nmea_sentence_checksum_framer_top.sv -----
// Top level of the NMEA sentence checksum framer.
//
// Input stream (s_*): one received character per request in s_tdata.
// A '$' in idle opens a sentence; the header runs to the first ',', data to
// '*', and every byte between '$' and '*' is XORed into the checksum. The two
// hex digits after '*' (upper or lower case, other characters read as 0) are
// compared with it. A sentence longer than MAX_LEN bytes is dropped.
// Output stream (m_*): a validated sentence, '$' through the second digit,
// one byte per request, m_tlast on the final digit. Bad sentences vanish.
// Throughput: one character per cycle while parsing. After a good sentence
// the input is held off during read-out of the store (one read port, a
// registered read): each byte is read and moved to the output register
// before the next read is issued. Read-out waits while m_tready is low;
// the last byte may still wait in the output register while input resumes.
// The first output byte passes the read-start, store and output registers.
// Reset (rst, synchronous) returns to idle and discards any pending output;
// the store itself is not cleared, only written entries are ever read.
`timescale 1ns / 1ps
`default_nettype none
module nmea_sentence_checksum_framer_top
  import nsc_pkg::*;
#(
  parameter int MAX_LEN = 64
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       s_tvalid,
  output logic            s_tready,
  input  wire logic [7:0] s_tdata,   // [7:0] rx_char
  output logic            m_tvalid,
  input  wire logic       m_tready,
  output logic [7:0]      m_tdata,   // [7:0] sentence_byte
  output logic            m_tlast    // last_byte
);

  wr_req_t   wr_req;
  emit_req_t emit_req;
  logic      busy;
  logic      accept;

  // Input is held off only while a sentence is being read out of the store.
  assign s_tready = !busy;
  assign accept   = s_tvalid && s_tready;

  nsc_parser #(
    .MAX_LEN(MAX_LEN)
  ) u_parser (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .rx_char  (s_tdata),
    .wr_req   (wr_req),
    .emit_req (emit_req)
  );

  nsc_store #(
    .MAX_LEN(MAX_LEN)
  ) u_store (
    .clk      (clk),
    .rst      (rst),
    .wr_req   (wr_req),
    .emit_req (emit_req),
    .busy     (busy),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

endmodule
`default_nettype wire
